[src/ffba_pkg.sv]
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

   // Request type codes
   localparam logic REQ_ALLOC    = 1'b0;
   localparam logic REQ_OWNER_WR = 1'b1;

   // Map entry that marks a free block, and the failure offset
   localparam logic [7:0]  FREE_MARK = 8'hFF;
   localparam logic [15:0] FAIL_CODE = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP_RD,
      ST_MAP_EVAL,
      ST_SIZE_RD,
      ST_SIZE_EVAL,
      ST_FILL,
      ST_DONE
   } ffba_state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic owner_write;
      logic load_req;
      logic set_fail;
      logic map_rd;
      logic size_rd;
      logic skip_one;
      logic skip_jump;
      logic advance_j;
      logic fill_start;
      logic fill_step;
      logic rsp_load;
   } ffba_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic req_write;
      logic req_id_bad;
      logic j_past_map;
      logic map_free;
      logic occ_known;
      logic j_is_pos;
      logic run_past_end;
      logic zero_blocks;
      logic run_last;
      logic rsp_free;
   } ffba_sts_type;

endpackage

[src/ffba_ctrl.sv]
// Sequencer for the allocator: clearing pass, map walk, fill and response.
module ffba_ctrl
   import ffba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ffba_sts_type sts,
   output ffba_cmd_type cmd
);

   ffba_state_type state_ff;
   ffba_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && !sts.req_write) begin
               state_in = sts.req_id_bad ? ST_DONE : ST_MAP_RD;
            end
         end
         ST_MAP_RD: begin
            state_in = sts.j_past_map ? ST_DONE : ST_MAP_EVAL;
         end
         ST_MAP_EVAL: begin
            if (!sts.map_free) begin
               state_in = sts.occ_known ? ST_SIZE_RD : ST_MAP_RD;
            end else if (sts.j_is_pos && (sts.run_past_end || sts.zero_blocks)) begin
               state_in = ST_DONE;
            end else if (sts.run_last) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_MAP_RD;
            end
         end
         ST_SIZE_RD:   state_in = ST_SIZE_EVAL;
         ST_SIZE_EVAL: state_in = ST_MAP_RD;
         ST_FILL: begin
            if (sts.run_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (sts.req_write) begin
                  cmd.owner_write = 1'b1;
               end else if (sts.req_id_bad) begin
                  cmd.set_fail = 1'b1;
               end else begin
                  cmd.load_req = 1'b1;
               end
            end
         end
         ST_MAP_RD: begin
            if (sts.j_past_map) begin
               cmd.set_fail = 1'b1;
            end else begin
               cmd.map_rd = 1'b1;
            end
         end
         ST_MAP_EVAL: begin
            if (!sts.map_free) begin
               cmd.skip_one = !sts.occ_known;
            end else if (sts.j_is_pos && sts.run_past_end) begin
               cmd.set_fail = 1'b1;
            end else if (sts.j_is_pos && sts.zero_blocks) begin
               cmd = '0;
            end else if (sts.run_last) begin
               cmd.fill_start = 1'b1;
            end else begin
               cmd.advance_j = 1'b1;
            end
         end
         ST_SIZE_RD:   cmd.size_rd = 1'b1;
         ST_SIZE_EVAL: cmd.skip_jump = 1'b1;
         ST_FILL:      cmd.fill_step = 1'b1;
         ST_DONE:      cmd.rsp_load = sts.rsp_free;
         default:      cmd = '0;
      endcase
   end

endmodule

[src/ffba_datapath.sv]
// Block map, owner size table, walk pointers and the response register.
module ffba_datapath
   import ffba_pkg::*;
#(
   parameter int MAP_BLOCKS  = 512,
   parameter int OWNER_COUNT = 96,
   parameter int BLOCK_SHIFT = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  ffba_cmd_type       cmd,
   output ffba_sts_type       sts,
   input  logic               req_type,
   input  logic [7:0]         req_owner_id,
   input  logic [15:0]        req_byte_size,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_byte_offset
);

   localparam int MAP_W = $clog2(MAP_BLOCKS);
   localparam int OWN_W = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
   localparam int POS_W = $clog2(MAP_BLOCKS + 2 ** 17);
   localparam int OFF_W = POS_W + BLOCK_SHIFT;

   // Memories
   logic [7:0]  map_mem [MAP_BLOCKS];
   logic [15:0] osz_mem [OWNER_COUNT];

   logic [OWNER_COUNT-1:0] osz_vld_ff, osz_vld_in;
   logic [MAP_W-1:0]       clr_addr_ff, clr_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_offset_ff, rsp_offset_in;
   logic [7:0]             id_ff, id_in;
   logic [15:0]            blocks_ff, blocks_in;
   logic [15:0]            rem_ff, rem_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [POS_W-1:0]       j_ff, j_in;
   logic                   fail_ff, fail_in;
   logic [7:0]             map_rdata_ff;
   logic [15:0]            size_rdata_ff;
   logic                   size_valid_ff;

   logic                   req_id_ok;
   logic [15:0]            size_skip;
   logic [POS_W-1:0]       skip_amt;
   logic [POS_W-1:0]       skip_pos;
   logic [OFF_W-1:0]       off_wide;

   assign req_id_ok = req_owner_id < 8'(OWNER_COUNT);

   // Skip distance for an occupied block
   always_comb begin
      size_skip = size_valid_ff ? (size_rdata_ff >> BLOCK_SHIFT) : 16'd0;
      if (cmd.skip_one || size_skip == 16'd0) begin
         skip_amt = POS_W'(1);
      end else begin
         skip_amt = POS_W'(size_skip);
      end
      skip_pos = j_ff + skip_amt;
   end

   assign off_wide = OFF_W'(pos_ff) << BLOCK_SHIFT;

   // Status towards the controller
   always_comb begin
      sts.clear_last   = clr_addr_ff == MAP_W'(MAP_BLOCKS - 1);
      sts.req_write    = req_type == REQ_OWNER_WR;
      sts.req_id_bad   = !req_id_ok;
      sts.j_past_map   = j_ff >= POS_W'(MAP_BLOCKS);
      sts.map_free     = map_rdata_ff == FREE_MARK;
      sts.occ_known    = map_rdata_ff < 8'(OWNER_COUNT);
      sts.j_is_pos     = j_ff == pos_ff;
      sts.run_past_end = (pos_ff + POS_W'(blocks_ff)) > POS_W'(MAP_BLOCKS);
      sts.zero_blocks  = blocks_ff == 16'd0;
      sts.run_last     = rem_ff == 16'd1;
      sts.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Next values of the walk and response registers
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      osz_vld_in    = osz_vld_ff;
      id_in         = id_ff;
      blocks_in     = blocks_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      fail_in       = fail_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;

      if (cmd.clear_step) clr_addr_in = clr_addr_ff + MAP_W'(1);
      if (cmd.owner_write && req_id_ok) begin
         osz_vld_in[req_owner_id[OWN_W-1:0]] = 1'b1;
      end
      if (cmd.load_req) begin
         id_in     = req_owner_id;
         blocks_in = req_byte_size >> BLOCK_SHIFT;
         rem_in    = req_byte_size >> BLOCK_SHIFT;
         pos_in    = '0;
         j_in      = '0;
         fail_in   = 1'b0;
      end
      if (cmd.set_fail) fail_in = 1'b1;
      if (cmd.skip_one || cmd.skip_jump) begin
         pos_in = skip_pos;
         j_in   = skip_pos;
         rem_in = blocks_ff;
      end
      if (cmd.advance_j || cmd.fill_step) begin
         j_in   = j_ff + POS_W'(1);
         rem_in = rem_ff - 16'd1;
      end
      if (cmd.fill_start) begin
         j_in   = pos_ff;
         rem_in = blocks_ff;
      end

      // Output register: taken by the receiver, then reloaded
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = fail_ff ? FAIL_CODE : off_wide[15:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         osz_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         osz_vld_ff   <= osz_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      blocks_ff     <= blocks_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      j_ff          <= j_in;
      fail_ff       <= fail_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   // Block map: clearing pass or fill writes, one probe read per cycle when a map read is commanded
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         map_mem[clr_addr_ff] <= FREE_MARK;
      end else if (cmd.fill_step) begin
         map_mem[j_ff[MAP_W-1:0]] <= id_ff;
      end
      if (cmd.map_rd) begin
         map_rdata_ff <= map_mem[j_ff[MAP_W-1:0]];
      end
   end

   // Owner size table; unwritten entries read as zero through the valid bits
   always_ff @(posedge clock) begin
      if (cmd.owner_write && req_id_ok) begin
         osz_mem[req_owner_id[OWN_W-1:0]] <= req_byte_size;
      end
      if (cmd.size_rd) begin
         size_rdata_ff <= osz_mem[map_rdata_ff[OWN_W-1:0]];
         size_valid_ff <= osz_vld_ff[map_rdata_ff[OWN_W-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_offset = rsp_offset_ff;

endmodule

[src/first_fit_block_allocator.sv]
// First-fit block allocator: top level joining the sequencer and the datapath.
//
// Request channel (req_valid/req_ready): req_type selects an allocation or an
// owner size write. A write stores req_byte_size for req_owner_id and gives no
// response. An allocation walks the block map first-fit
// from block 0 and gives one response on rsp_valid/rsp_ready: the start block
// index shifted by BLOCK_SHIFT, or -1 when the owner id is out of range or no
// run fits.
// An allocation reads and then evaluates each block it probes; where an
// occupied block's owner size is looked up to skip ahead, a size read and a
// skip step follow. The run found is then filled block by block and the
// response is loaded; a bad owner id goes straight to the response.
// One request is worked on at a time; the next request is taken once the
// response is in the output register, even if the receiver has not taken it.
// After reset the block map is cleared to free, one block per cycle, over all
// MAP_BLOCKS blocks; req_ready stays low until that pass ends.
// A stalled receiver holds the response; an allocation that finishes meanwhile
// waits for the output register before the block takes more requests.
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAP_BLOCKS  = 512,
   parameter int OWNER_COUNT = 96,
   parameter int BLOCK_SHIFT = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [7:0]         req_owner_id,
   input  logic [15:0]        req_byte_size,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_byte_offset
);

   ffba_cmd_type cmd;
   ffba_sts_type sts;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffba_datapath #(
      .MAP_BLOCKS  (MAP_BLOCKS),
      .OWNER_COUNT (OWNER_COUNT),
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_owner_id    (req_owner_id),
      .req_byte_size   (req_byte_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_offset (rsp_byte_offset)
   );

`ifndef ASSERT_OFF
   // Map probes and fill writes stay inside the map
   a_probe_in_map: assert property (@(posedge clock) disable iff (reset)
      (cmd.map_rd || cmd.fill_step) |-> !sts.j_past_map)
      else $error("block map accessed past its end");

   // An accepted allocation drops req_ready until its response is loaded
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_ALLOC) |=> !req_ready)
      else $error("request taken while an allocation is in progress");

   // A new response never overwrites one the receiver has not taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("pending response lost");

   // Fill only starts on a free block
   a_fill_on_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_start |-> sts.map_free)
      else $error("fill started on an occupied block");
`endif

endmodule
